>>> sv/bjm_pkg.sv
package bjm_pkg;

    localparam int MAX_ORDER = 127;
    localparam int MAX_START = 255;
    localparam int MIN_START = 20;

    localparam int ORD_W   = 7;
    localparam int START_W = 9;
    localparam int IDX_W   = $clog2(MAX_START + 1);
    localparam int SQ_W    = 6;
    localparam int K_W     = IDX_W + 2;

    localparam logic [63:0] FP_ONE  = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] FP_TWO  = 64'h4000_0000_0000_0000;
    localparam logic [63:0] FP_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] FP_DNAN = 64'hFFF8_0000_0000_0000;

    typedef logic [1:0] fpu_op_t;
    localparam fpu_op_t FOP_ADD = 2'd0;
    localparam fpu_op_t FOP_SUB = 2'd1;
    localparam fpu_op_t FOP_MUL = 2'd2;
    localparam fpu_op_t FOP_DIV = 2'd3;

    typedef logic [3:0] src_t;
    localparam src_t SRC_K    = 4'd0;
    localparam src_t SRC_X    = 4'd1;
    localparam src_t SRC_TMP  = 4'd2;
    localparam src_t SRC_JP1  = 4'd3;
    localparam src_t SRC_JP2  = 4'd4;
    localparam src_t SRC_CUR  = 4'd5;
    localparam src_t SRC_NORM = 4'd6;
    localparam src_t SRC_TWO  = 4'd7;
    localparam src_t SRC_JN   = 4'd8;

    typedef logic [1:0] dst_t;
    localparam dst_t DST_TMP  = 2'd0;
    localparam dst_t DST_CUR  = 2'd1;
    localparam dst_t DST_NORM = 2'd2;

    typedef struct packed {
        logic    load;
        logic    zero_res;
        logic    sq_step;
        logic    set_start;
        logic    fpu_start;
        fpu_op_t fpu_op;
        src_t    src_a;
        src_t    src_b;
        logic    fpu_wr;
        dst_t    dst;
        logic    advance;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic x_zero;
        logic start_auto;
        logic sq_more;
        logic i_even;
        logic i_zero;
        logic fpu_done;
    } dp_stat_t;

    // Exact double encoding of a small positive integer.
    function automatic logic [63:0] k_to_double(input logic [K_W-1:0] k);
        logic [3:0]  p;
        logic [52:0] m;
        logic [10:0] ex;
        p = '0;
        for (int b = 0; b < K_W; b++) begin
            if (k[b]) begin
                p = 4'(b);
            end
        end
        m  = 53'(k) << (6'd52 - 6'(p));
        ex = 11'(1023) + 11'(p);
        return {1'b0, ex, m[51:0]};
    endfunction

endpackage

>>> sv/bjm_fpu.sv
module bjm_fpu (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  bjm_pkg::fpu_op_t op,
    input  logic [63:0]      a,
    input  logic [63:0]      b,
    output logic             done,
    output logic [63:0]      result
);
    import bjm_pkg::*;

    localparam int RW = 117;

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_SETUP = 3'd1;
    localparam logic [2:0] F_PRE   = 3'd2;
    localparam logic [2:0] F_MUL   = 3'd3;
    localparam logic [2:0] F_DIV   = 3'd4;
    localparam logic [2:0] F_NORM  = 3'd5;
    localparam logic [2:0] F_DEN   = 3'd6;
    localparam logic [2:0] F_RND   = 3'd7;

    logic [2:0]         state_reg, state_next;
    fpu_op_t            op_reg, op_next;
    logic [63:0]        a_reg, a_next, b_reg, b_next;
    logic               sign_reg, sign_next;
    logic signed [13:0] e_reg, e_next, ea_reg, ea_next, eb_reg, eb_next;
    logic [RW-1:0]      r_reg, r_next;
    logic               stk_reg, stk_next;
    logic [52:0]        ma_reg, ma_next;
    logic [55:0]        mb_reg, mb_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic [54:0]        rem_reg, rem_next;
    logic [63:0]        res_reg, res_next;
    logic               done_reg, done_next;

    // operand decode
    logic [10:0]        ea_f, eb_f, ea_eff, eb_eff;
    logic [52:0]        sig_a, sig_b;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic               sx, sb_eff;
    logic signed [13:0] ea_s, eb_s;

    // alignment add
    logic               a_ge;
    logic [52:0]        big_sig, sml_sig;
    logic [10:0]        big_e, sml_e, al_d;
    logic [6:0]         al_sh;
    logic [RW-1:0]      al_full, al_shd, al_sml, al_big, al_sum;
    logic               al_stk, big_sign;

    // multiply step
    logic [66:0]        mul_pp;
    logic [RW-1:0]      mul_acc;

    // divide step
    logic               dv_ge;
    logic [54:0]        dv_dif, dv_rem;
    logic [65:0]        dv_q;

    // denormalize and round
    logic signed [13:0] dn_d;
    logic [6:0]         dn_sh;
    logic [RW-1:0]      dn_r;
    logic               rnd_up, ovf;
    logic [53:0]        s54;
    logic signed [13:0] ef;

    assign ea_f   = a_reg[62:52];
    assign eb_f   = b_reg[62:52];
    assign ea_eff = (ea_f == 11'd0) ? 11'd1 : ea_f;
    assign eb_eff = (eb_f == 11'd0) ? 11'd1 : eb_f;
    assign sig_a  = {ea_f != 11'd0, a_reg[51:0]};
    assign sig_b  = {eb_f != 11'd0, b_reg[51:0]};
    assign a_nan  = (ea_f == 11'h7FF) && (a_reg[51:0] != 52'd0);
    assign b_nan  = (eb_f == 11'h7FF) && (b_reg[51:0] != 52'd0);
    assign a_inf  = (ea_f == 11'h7FF) && (a_reg[51:0] == 52'd0);
    assign b_inf  = (eb_f == 11'h7FF) && (b_reg[51:0] == 52'd0);
    assign a_zero = (a_reg[62:0] == 63'd0);
    assign b_zero = (b_reg[62:0] == 63'd0);
    assign sx     = a_reg[63] ^ b_reg[63];
    assign sb_eff = b_reg[63] ^ (op_reg == FOP_SUB);
    assign ea_s   = $signed({3'b000, ea_eff});
    assign eb_s   = $signed({3'b000, eb_eff});

    assign a_ge     = {ea_eff, sig_a} >= {eb_eff, sig_b};
    assign big_sig  = a_ge ? sig_a : sig_b;
    assign sml_sig  = a_ge ? sig_b : sig_a;
    assign big_e    = a_ge ? ea_eff : eb_eff;
    assign sml_e    = a_ge ? eb_eff : ea_eff;
    assign big_sign = a_ge ? a_reg[63] : sb_eff;
    assign al_d     = big_e - sml_e;
    assign al_sh    = (al_d > 11'd116) ? 7'd117 : al_d[6:0];
    assign al_full  = {1'b0, sml_sig, 63'd0};
    assign al_shd   = al_full >> al_sh;
    assign al_stk   = (al_shd << al_sh) != al_full;
    assign al_sml   = al_shd | {{(RW-1){1'b0}}, al_stk};
    assign al_big   = {1'b0, big_sig, 63'd0};
    assign al_sum   = (a_reg[63] ^ sb_eff) ? (al_big - al_sml) : (al_big + al_sml);

    assign mul_pp  = ma_reg * mb_reg[55:42];
    assign mul_acc = {r_reg[RW-15:0], 14'd0} + RW'(mul_pp);

    assign dv_ge  = rem_reg >= {2'b00, mb_reg[52:0]};
    assign dv_dif = rem_reg - {2'b00, mb_reg[52:0]};
    assign dv_rem = dv_ge ? {dv_dif[53:0], 1'b0} : {rem_reg[53:0], 1'b0};
    assign dv_q   = {r_reg[64:0], dv_ge};

    assign dn_d  = 14'sd1 - e_reg;
    assign dn_sh = (dn_d > 14'sd117) ? 7'd117 : dn_d[6:0];
    assign dn_r  = r_reg >> dn_sh;

    assign rnd_up = r_reg[62] & ((|r_reg[61:0]) | stk_reg | r_reg[63]);
    assign s54    = {1'b0, r_reg[115:63]} + {53'd0, rnd_up};
    assign ef     = s54[53] ? (e_reg + 14'sd1) : (s54[52] ? e_reg : 14'sd0);
    assign ovf    = (r_reg != '0) && (ef >= 14'sd2047);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        sign_next  = sign_reg;
        e_next     = e_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        r_next     = r_reg;
        stk_next   = stk_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    a_next     = a;
                    b_next     = b;
                    op_next    = op;
                    state_next = F_SETUP;
                end
            end
            F_SETUP:
            begin
                // NaN operands win; the first one is passed on, quieted
                if (a_nan)
                begin
                    res_next   = a_reg | 64'h0008_0000_0000_0000;
                    done_next  = 1'b1;
                    state_next = F_IDLE;
                end
                else if (b_nan)
                begin
                    res_next   = b_reg | 64'h0008_0000_0000_0000;
                    done_next  = 1'b1;
                    state_next = F_IDLE;
                end
                else
                begin
                    case (op_reg)
                        FOP_MUL:
                        begin
                            if ((a_inf && b_zero) || (a_zero && b_inf))
                            begin
                                res_next   = FP_DNAN;
                                done_next  = 1'b1;
                                state_next = F_IDLE;
                            end
                            else if (a_inf || b_inf)
                            begin
                                res_next   = {sx, 11'h7FF, 52'd0};
                                done_next  = 1'b1;
                                state_next = F_IDLE;
                            end
                            else
                            begin
                                ma_next    = sig_a;
                                mb_next    = {3'b000, sig_b};
                                r_next     = '0;
                                stk_next   = 1'b0;
                                cnt_next   = '0;
                                sign_next  = sx;
                                e_next     = ea_s + eb_s - 14'sd1023;
                                state_next = F_MUL;
                            end
                        end
                        FOP_DIV:
                        begin
                            if ((a_inf && b_inf) || (a_zero && b_zero))
                            begin
                                res_next   = FP_DNAN;
                                done_next  = 1'b1;
                                state_next = F_IDLE;
                            end
                            else if (a_inf || b_zero)
                            begin
                                res_next   = {sx, 11'h7FF, 52'd0};
                                done_next  = 1'b1;
                                state_next = F_IDLE;
                            end
                            else if (b_inf || a_zero)
                            begin
                                res_next   = {sx, 63'd0};
                                done_next  = 1'b1;
                                state_next = F_IDLE;
                            end
                            else
                            begin
                                ma_next    = sig_a;
                                mb_next    = {3'b000, sig_b};
                                ea_next    = ea_s;
                                eb_next    = eb_s;
                                sign_next  = sx;
                                state_next = F_PRE;
                            end
                        end
                        default:
                        begin
                            if (a_inf && b_inf && (a_reg[63] != sb_eff))
                            begin
                                res_next   = FP_DNAN;
                                done_next  = 1'b1;
                                state_next = F_IDLE;
                            end
                            else if (a_inf)
                            begin
                                res_next   = a_reg;
                                done_next  = 1'b1;
                                state_next = F_IDLE;
                            end
                            else if (b_inf)
                            begin
                                res_next   = {sb_eff, b_reg[62:0]};
                                done_next  = 1'b1;
                                state_next = F_IDLE;
                            end
                            else
                            begin
                                r_next     = al_sum;
                                stk_next   = 1'b0;
                                e_next     = $signed({3'b000, big_e});
                                sign_next  = (al_sum == '0) ? (a_reg[63] & sb_eff) : big_sign;
                                state_next = F_NORM;
                            end
                        end
                    endcase
                end
            end
            F_PRE:
            begin
                // bring subnormal significands up to a leading one
                if (!ma_reg[52])
                begin
                    ma_next = {ma_reg[51:0], 1'b0};
                    ea_next = ea_reg - 14'sd1;
                end
                if (!mb_reg[52])
                begin
                    mb_next = {mb_reg[54:0], 1'b0};
                    eb_next = eb_reg - 14'sd1;
                end
                if (ma_reg[52] && mb_reg[52])
                begin
                    rem_next   = {2'b00, ma_reg};
                    r_next     = '0;
                    cnt_next   = '0;
                    state_next = F_DIV;
                end
            end
            F_MUL:
            begin
                mb_next  = {mb_reg[41:0], 14'd0};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd3)
                begin
                    r_next     = mul_acc << 11;
                    state_next = F_NORM;
                end
                else
                begin
                    r_next = mul_acc;
                end
            end
            F_DIV:
            begin
                rem_next = dv_rem;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd65)
                begin
                    r_next     = {1'b0, dv_q, 50'd0};
                    stk_next   = (dv_rem != 55'd0);
                    e_next     = ea_reg - eb_reg + 14'sd1023;
                    state_next = F_NORM;
                end
                else
                begin
                    r_next = {r_reg[RW-2:0], dv_ge};
                end
            end
            F_NORM:
            begin
                if (r_reg[RW-1])
                begin
                    r_next   = r_reg >> 1;
                    stk_next = stk_reg | r_reg[0];
                    e_next   = e_reg + 14'sd1;
                end
                else if ((r_reg != '0) && !r_reg[115] && (e_reg > 14'sd1))
                begin
                    if ((r_reg[115:100] == 16'd0) && (e_reg > 14'sd16))
                    begin
                        r_next = r_reg << 16;
                        e_next = e_reg - 14'sd16;
                    end
                    else
                    begin
                        r_next = r_reg << 1;
                        e_next = e_reg - 14'sd1;
                    end
                end
                else
                begin
                    state_next = F_DEN;
                end
            end
            F_DEN:
            begin
                if (e_reg < 14'sd1)
                begin
                    r_next   = dn_r;
                    stk_next = stk_reg | ((dn_r << dn_sh) != r_reg);
                    e_next   = 14'sd1;
                end
                state_next = F_RND;
            end
            F_RND:
            begin
                res_next   = ovf ? {sign_reg, 11'h7FF, 52'd0} : {sign_reg, ef[10:0], s54[51:0]};
                done_next  = 1'b1;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        sign_reg <= sign_next;
        e_reg    <= e_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        r_reg    <= r_next;
        stk_reg  <= stk_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> sv/bjm_datapath.sv
module bjm_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bjm_pkg::dp_cmd_t                 cmd,
    input  logic [63:0]                      x_bits,
    input  logic [bjm_pkg::ORD_W-1:0]        order,
    input  logic signed [bjm_pkg::START_W-1:0] start_override,
    output bjm_pkg::dp_stat_t                stat,
    output logic [63:0]                      jn_bits
);
    import bjm_pkg::*;

    logic [63:0]        x_reg, jp1_reg, jp2_reg, cur_reg, tmp_reg, norm_reg, jn_reg, out_reg;
    logic [ORD_W-1:0]   n_reg, n_sat;
    logic [START_W-1:0] st_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [SQ_W-1:0]    sq_reg;

    logic [K_W-1:0]     k_val;
    logic [63:0]        op_a, op_b, fpu_res;
    logic               fpu_done;
    logic [13:0]        sq_t, sq_sq, ten_n;
    logic [START_W:0]   s_base, s_1, s_2, s_3;

    assign n_sat = (32'(order) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : order;
    assign k_val = {(K_W-1)'(i_reg) + (K_W-1)'(1), 1'b0};

    function automatic logic [63:0] pick(input src_t s, input logic [K_W-1:0] k,
                                         input logic [63:0] x, input logic [63:0] t,
                                         input logic [63:0] p1, input logic [63:0] p2,
                                         input logic [63:0] c, input logic [63:0] nm,
                                         input logic [63:0] jn);
        logic [63:0] v;
        case (s)
            SRC_K:    v = k_to_double(k);
            SRC_X:    v = x;
            SRC_TMP:  v = t;
            SRC_JP1:  v = p1;
            SRC_JP2:  v = p2;
            SRC_CUR:  v = c;
            SRC_NORM: v = nm;
            SRC_TWO:  v = FP_TWO;
            SRC_JN:   v = jn;
            default:  v = FP_ZERO;
        endcase
        return v;
    endfunction

    assign op_a = pick(cmd.src_a, k_val, x_reg, tmp_reg, jp1_reg, jp2_reg, cur_reg,
                       norm_reg, jn_reg);
    assign op_b = pick(cmd.src_b, k_val, x_reg, tmp_reg, jp1_reg, jp2_reg, cur_reg,
                       norm_reg, jn_reg);

    // integer square root of 10n, one candidate per cycle
    assign sq_t  = 14'(sq_reg) + 14'd1;
    assign sq_sq = sq_t * sq_t;
    assign ten_n = 14'(n_reg) * 14'd10;

    // start index with its clamps
    assign s_base = st_reg[START_W-1]
                  ? (START_W+1)'(n_reg) + (START_W+1)'(sq_reg) + (START_W+1)'(1)
                  : (START_W+1)'(st_reg);
    assign s_1 = (32'(s_base) < MIN_START) ? (START_W+1)'(MIN_START) : s_base;
    assign s_2 = (32'(s_1) > MAX_START) ? (START_W+1)'(MAX_START) : s_1;
    assign s_3 = (s_2 < (START_W+1)'(n_reg)) ? (START_W+1)'(n_reg) : s_2;

    bjm_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.fpu_start),
        .op     (cmd.fpu_op),
        .a      (op_a),
        .b      (op_b),
        .done   (fpu_done),
        .result (fpu_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg  <= x_bits;
            n_reg  <= n_sat;
            st_reg <= start_override;
            sq_reg <= '0;
        end
        if (cmd.sq_step)
        begin
            sq_reg <= sq_reg + SQ_W'(1);
        end
        if (cmd.zero_res)
        begin
            tmp_reg <= (n_reg == '0) ? FP_ONE : FP_ZERO;
        end
        if (cmd.set_start)
        begin
            i_reg    <= s_3[IDX_W-1:0];
            jp1_reg  <= FP_ONE;
            jp2_reg  <= FP_ONE;
            norm_reg <= FP_ONE;
            jn_reg   <= FP_ZERO;
        end
        if (cmd.fpu_wr)
        begin
            case (cmd.dst)
                DST_TMP:  tmp_reg  <= fpu_res;
                DST_CUR:  cur_reg  <= fpu_res;
                DST_NORM: norm_reg <= fpu_res;
                default:  tmp_reg  <= fpu_res;
            endcase
        end
        if (cmd.advance)
        begin
            // shift the recurrence window down one index
            jp2_reg <= jp1_reg;
            jp1_reg <= cur_reg;
            if (IDX_W'(n_reg) == i_reg)
            begin
                jn_reg <= cur_reg;
            end
            if (i_reg != '0)
            begin
                i_reg <= i_reg - IDX_W'(1);
            end
        end
        if (cmd.out_load)
        begin
            out_reg <= tmp_reg;
        end
    end

    assign stat.x_zero     = (x_reg[62:0] == 63'd0);
    assign stat.start_auto = st_reg[START_W-1];
    assign stat.sq_more    = (sq_sq <= ten_n);
    assign stat.i_even     = !i_reg[0];
    assign stat.i_zero     = (i_reg == '0);
    assign stat.fpu_done   = fpu_done;

    assign jn_bits = out_reg;

endmodule

>>> sv/bjm_ctrl.sv
module bjm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bjm_pkg::dp_stat_t stat,
    output bjm_pkg::dp_cmd_t  cmd
);
    import bjm_pkg::*;

    localparam logic [4:0] C_IDLE  = 5'd0;
    localparam logic [4:0] C_CHK   = 5'd1;
    localparam logic [4:0] C_SQ    = 5'd2;
    localparam logic [4:0] C_SETS  = 5'd3;
    localparam logic [4:0] C_DIVK  = 5'd4;
    localparam logic [4:0] C_WDIVK = 5'd5;
    localparam logic [4:0] C_MUL   = 5'd6;
    localparam logic [4:0] C_WMUL  = 5'd7;
    localparam logic [4:0] C_SUB   = 5'd8;
    localparam logic [4:0] C_WSUB  = 5'd9;
    localparam logic [4:0] C_DBL   = 5'd10;
    localparam logic [4:0] C_WDBL  = 5'd11;
    localparam logic [4:0] C_ACC   = 5'd12;
    localparam logic [4:0] C_WACC  = 5'd13;
    localparam logic [4:0] C_STEP  = 5'd14;
    localparam logic [4:0] C_FDIV  = 5'd15;
    localparam logic [4:0] C_WFDIV = 5'd16;
    localparam logic [4:0] C_OUT   = 5'd17;

    logic [4:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = C_CHK;
                end
            end
            C_CHK:
            begin
                if (stat.x_zero)
                begin
                    cmd.zero_res = 1'b1;
                    state_next   = C_OUT;
                end
                else if (stat.start_auto)
                begin
                    state_next = C_SQ;
                end
                else
                begin
                    state_next = C_SETS;
                end
            end
            C_SQ:
            begin
                if (stat.sq_more)
                begin
                    cmd.sq_step = 1'b1;
                end
                else
                begin
                    state_next = C_SETS;
                end
            end
            C_SETS:
            begin
                cmd.set_start = 1'b1;
                state_next    = C_DIVK;
            end
            C_DIVK:
            begin
                cmd.fpu_start = 1'b1;
                cmd.fpu_op    = FOP_DIV;
                cmd.src_a     = SRC_K;
                cmd.src_b     = SRC_X;
                state_next    = C_WDIVK;
            end
            C_WDIVK:
            begin
                cmd.dst = DST_TMP;
                if (stat.fpu_done)
                begin
                    cmd.fpu_wr = 1'b1;
                    state_next = C_MUL;
                end
            end
            C_MUL:
            begin
                cmd.fpu_start = 1'b1;
                cmd.fpu_op    = FOP_MUL;
                cmd.src_a     = SRC_TMP;
                cmd.src_b     = SRC_JP1;
                state_next    = C_WMUL;
            end
            C_WMUL:
            begin
                cmd.dst = DST_TMP;
                if (stat.fpu_done)
                begin
                    cmd.fpu_wr = 1'b1;
                    state_next = C_SUB;
                end
            end
            C_SUB:
            begin
                cmd.fpu_start = 1'b1;
                cmd.fpu_op    = FOP_SUB;
                cmd.src_a     = SRC_TMP;
                cmd.src_b     = SRC_JP2;
                state_next    = C_WSUB;
            end
            C_WSUB:
            begin
                cmd.dst = DST_CUR;
                if (stat.fpu_done)
                begin
                    cmd.fpu_wr = 1'b1;
                    // even terms feed the normalization sum
                    if (!stat.i_even)
                    begin
                        state_next = C_STEP;
                    end
                    else if (stat.i_zero)
                    begin
                        state_next = C_ACC;
                    end
                    else
                    begin
                        state_next = C_DBL;
                    end
                end
            end
            C_DBL:
            begin
                cmd.fpu_start = 1'b1;
                cmd.fpu_op    = FOP_MUL;
                cmd.src_a     = SRC_TWO;
                cmd.src_b     = SRC_CUR;
                state_next    = C_WDBL;
            end
            C_WDBL:
            begin
                cmd.dst = DST_TMP;
                if (stat.fpu_done)
                begin
                    cmd.fpu_wr = 1'b1;
                    state_next = C_ACC;
                end
            end
            C_ACC:
            begin
                cmd.fpu_start = 1'b1;
                cmd.fpu_op    = FOP_ADD;
                cmd.src_a     = SRC_NORM;
                cmd.src_b     = stat.i_zero ? SRC_CUR : SRC_TMP;
                state_next    = C_WACC;
            end
            C_WACC:
            begin
                cmd.dst = DST_NORM;
                if (stat.fpu_done)
                begin
                    cmd.fpu_wr = 1'b1;
                    state_next = C_STEP;
                end
            end
            C_STEP:
            begin
                cmd.advance = 1'b1;
                state_next  = stat.i_zero ? C_FDIV : C_DIVK;
            end
            C_FDIV:
            begin
                cmd.fpu_start = 1'b1;
                cmd.fpu_op    = FOP_DIV;
                cmd.src_a     = SRC_JN;
                cmd.src_b     = SRC_NORM;
                state_next    = C_WFDIV;
            end
            C_WFDIV:
            begin
                cmd.dst = DST_TMP;
                if (stat.fpu_done)
                begin
                    cmd.fpu_wr = 1'b1;
                    state_next = C_OUT;
                end
            end
            C_OUT:
            begin
                // hold until the output register is free
                if (!ovalid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    assign ovalid_next = cmd.out_load | (ovalid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= C_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

endmodule

>>> sv/bessel_jn_miller_recurrence.sv
// J_n(x) by Miller's backward recurrence in IEEE double precision.
//
// Input channel (in_valid/in_ready) carries one beat: x_bits (double bit
// pattern), order n and start_override (9-bit signed, negative = automatic
// start n + isqrt(10n) + 1). The start is clamped to 20..255 and raised to n.
// Output channel (out_valid/out_ready) returns one beat: jn_bits.
//
// One item is processed at a time. A single shared floating-point unit runs
// every add, multiply and divide; its radix-2 divider sets the pace. An even
// recurrence index runs more steps than an odd one: the normalization sum
// adds a doubling (not at index zero) and an add. The automatic start search
// adds its own steps, and a zero argument skips the recurrence. Subnormal
// divide operands are first shifted up to a leading one.
//
// The result sits in an output register: a stalled receiver does not block a
// new input beat, but the next result waits until the register is drained.
// Reset returns the controller to idle and drops any pending result.
module bessel_jn_miller_recurrence (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [63:0]                        x_bits,
    input  logic [bjm_pkg::ORD_W-1:0]          order,
    input  logic signed [bjm_pkg::START_W-1:0] start_override,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [63:0]                        jn_bits
);
    import bjm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: issues one floating-point command at a time
    bjm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // recurrence registers, start logic and the shared floating-point unit
    bjm_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .x_bits         (x_bits),
        .order          (order),
        .start_override (start_override),
        .stat           (stat),
        .jn_bits        (jn_bits)
    );

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    import bjm_pkg::*;

    typedef struct {
        logic [63:0]                x;
        logic [ORD_W-1:0]           n;
        logic signed [START_W-1:0]  st;
        bit                         drain;   // wait for an empty pipeline first
    } jn_req_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [63:0]                x_bits = '0;
    logic [ORD_W-1:0]           order = '0;
    logic signed [START_W-1:0]  start_override = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [63:0]                jn_bits;

    jn_req_t     req_q[$];       // beats waiting to be sent
    logic [63:0] jn_expect_q[$]; // predicted results, oldest first
    int          errors = 0;
    int          in_gap = 0;
    int          out_stall = 0;
    int          idle_cycles = 0;
    bit          quiet_tail = 1'b0;

    localparam int WATCHDOG_LIMIT = 200000;

    bessel_jn_miller_recurrence dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .x_bits         (x_bits),
        .order          (order),
        .start_override (start_override),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .jn_bits        (jn_bits)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predict J_n(x): backward recurrence from the clamped start index,
    // normalized by J0 + 2*(even terms) on top of the seed of one.
    function automatic logic [63:0] miller_jn(input logic [63:0] xb,
                                              input logic [ORD_W-1:0] n,
                                              input logic signed [START_W-1:0] so);
        real x;
        real jp1;
        real jp2;
        real jc;
        real jn;
        real norm;
        int  s;
        int  r;
        x = $bitstoreal(xb);
        if (x == 0.0)
        begin
            return (n == 0) ? FP_ONE : FP_ZERO;
        end
        if (so < 0)
        begin
            r = 0;
            while ((r + 1) * (r + 1) <= 10 * int'(n))
                r++;
            s = int'(n) + r + 1;
        end
        else
        begin
            s = int'(so);
        end
        if (s < MIN_START)
            s = MIN_START;
        if (s > MAX_START)
            s = MAX_START;
        if (s < int'(n))
            s = int'(n);
        jp1  = 1.0;
        jp2  = 1.0;
        jn   = 0.0;
        norm = 1.0;
        for (int i = s; i >= 0; i--)
        begin
            jc  = (real'(2 * (i + 1)) / x) * jp1 - jp2;
            jp2 = jp1;
            if (i % 2 == 0)
                norm = (i == 0) ? norm + jc : norm + 2.0 * jc;
            if (i == int'(n))
                jn = jc;
            jp1 = jc;
        end
        return $realtobits(jn / norm);
    endfunction

    function automatic bit is_nan(input logic [63:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != '0);
    endfunction

    // Append one request to the pending list.
    function automatic void add_req(input jn_req_t r);
        req_q.insert(req_q.size(), r);
    endfunction

    // Driver: hold the beat until accepted, then insert random idle bursts.
    always @(posedge clk)
    begin
        jn_req_t r;
        bit      busy;
        if (rst_n)
        begin
            busy = in_valid;
            if (in_valid && in_ready)
            begin
                jn_expect_q.insert(jn_expect_q.size(),
                                   miller_jn(x_bits, order, start_override));
                busy = 1'b0;
                if (!quiet_tail && $urandom_range(0, 3) == 0)
                    in_gap = $urandom_range(1, 8);
            end
            if (!busy)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (req_q.size() > 0 &&
                         !(req_q[0].drain && jn_expect_q.size() > 0))
                begin
                    r = req_q.pop_front();
                    in_valid       <= 1'b1;
                    x_bits         <= r.x;
                    order          <= r.n;
                    start_override <= r.st;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (jn_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat: expected none, actual %h",
                             $time, jn_bits);
                    errors++;
                end
                else
                begin
                    want = jn_expect_q.pop_front();
                    // NaN payloads are not pinned down; any NaN matches a NaN.
                    if (!(want === jn_bits || (is_nan(want) && is_nan(jn_bits))))
                    begin
                        $display("%0t: jn_bits mismatch: expected %h, actual %h",
                                 $time, want, jn_bits);
                        errors++;
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_stall = $urandom_range(0, 7);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles with no beat on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic jn_req_t mk_req(input logic [63:0] x, input int n, input int st,
                                       input bit drain);
        jn_req_t r;
        r.x     = x;
        r.n     = ORD_W'(n);
        r.st    = START_W'(st);
        r.drain = drain;
        return r;
    endfunction

    // Random argument: mostly moderate reals, some raw bit patterns.
    function automatic logic [63:0] rand_x();
        real v;
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        v = (real'($urandom_range(0, 200000)) - 100000.0) / 2000.0;
        return $realtobits(v);
    endfunction

    initial
    begin
        jn_req_t r;
        // zero argument, both signs, orders zero and nonzero
        add_req(mk_req(64'h0000_0000_0000_0000, 0, -1, 0));
        add_req(mk_req(64'h8000_0000_0000_0000, 0, -1, 0));
        add_req(mk_req(64'h0000_0000_0000_0000, 5, 30, 0));
        add_req(mk_req(64'h8000_0000_0000_0000, 127, -256, 0));
        // NaN and infinities run through the recurrence
        add_req(mk_req(64'hFFFF_FFFF_FFFF_FFFF, 3, -1, 0));
        add_req(mk_req(64'h7FF0_0000_0000_0000, 1, -1, 0));
        add_req(mk_req(64'hFFF0_0000_0000_0000, 2, 20, 0));
        // tiny subnormal and huge arguments, negative argument
        add_req(mk_req(64'h0000_0000_0000_0001, 0, 0, 0));
        add_req(mk_req(64'h7FEF_FFFF_FFFF_FFFF, 4, -1, 0));
        add_req(mk_req($realtobits(-3.5), 2, -1, 1));
        add_req(mk_req($realtobits(1.0), 0, -1, 0));
        // small start raised to the floor, start below the order raised to it
        add_req(mk_req($realtobits(2.5), 1, 0, 0));
        add_req(mk_req($realtobits(2.5), 1, 19, 0));
        add_req(mk_req($realtobits(10.0), 100, 30, 0));
        // largest start, largest order with automatic start
        add_req(mk_req($realtobits(7.25), 10, 255, 0));
        add_req(mk_req($realtobits(40.0), 127, -1, 0));
        add_req(mk_req($realtobits(0.001), 127, 127, 1));
        add_req(mk_req($realtobits(5.0), 6, -1, 0));
        for (int k = 0; k < 750; k++)
        begin
            r.x     = rand_x();
            r.drain = ($urandom_range(0, 99) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                r.n  = ORD_W'($urandom);
                r.st = START_W'($urandom);
            end
            else
            begin
                r.n  = ORD_W'($urandom_range(0, 20));
                r.st = ($urandom_range(0, 1) == 0) ? START_W'(-$urandom_range(1, 256))
                                                   : START_W'($urandom_range(0, 35));
            end
            add_req(r);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (req_q.size() < 60);
        quiet_tail = 1'b1;
        // sample at the falling edge, once every clocked update has settled
        do
            @(negedge clk);
        while (req_q.size() != 0 || in_valid || jn_expect_q.size() != 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && jn_expect_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
sv/bjm_pkg.sv
sv/bjm_fpu.sv
sv/bjm_datapath.sv
sv/bjm_ctrl.sv
sv/bessel_jn_miller_recurrence.sv
tb/sv/tb_top.sv
